>>> rtl/core/jss_pkg.sv
// ----------------------------------------------------------------------------
// jss_pkg: shared constants and types of the job slice scheduler
// Sizes of the job table, the field widths, the policy codes, the configuration indexes and the sequencer states.
// ----------------------------------------------------------------------------
package jss_pkg;

    localparam int MAX_JOBS = 64;
    localparam int ID_W     = $clog2(MAX_JOBS);
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);
    localparam int LEN_W    = 16;
    localparam int CLK_W    = 23;
    localparam int SUM_W    = 29;
    localparam int PAD_W    = CLK_W - LEN_W;

    // Policy codes.
    localparam logic [1:0] POL_FIFO = 2'd0;
    localparam logic [1:0] POL_SJF  = 2'd1;
    localparam logic [1:0] POL_RR   = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_POLICY    = 1'b0;
    localparam logic CFG_TIMESLICE = 1'b1;

    // Sequencer states.
    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_SCAN   = 13'b0000000000010,
        S_SJF    = 13'b0000000000100,
        S_RDID   = 13'b0000000001000,
        S_GETID  = 13'b0000000010000,
        S_JOBRD  = 13'b0000000100000,
        S_JOBDAT = 13'b0000001000000,
        S_CALC   = 13'b0000010000000,
        S_MARK   = 13'b0000100000000,
        S_FIN    = 13'b0001000000000,
        S_SUM    = 13'b0010000000000,
        S_REMOVE = 13'b0100000000000,
        S_EMIT   = 13'b1000000000000
    } state_t;

    // What a pass over the job table is doing.
    typedef enum logic [3:0] {
        K_ADM_PRE  = 4'b0001,
        K_MIN      = 4'b0010,
        K_ADM_JUMP = 4'b0100,
        K_ADM_POST = 4'b1000
    } scan_kind_t;

endpackage

>>> rtl/core/jss_ram.sv
// ----------------------------------------------------------------------------
// jss_ram: simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module jss_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/job_slice_scheduler_unit.sv
// ----------------------------------------------------------------------------
// job_slice_scheduler_unit: FIFO, shortest-job-first and round-robin scheduler
// Loads jobs into a table and runs one time slice per dispatch item.
// ----------------------------------------------------------------------------
// A dispatch item is worked by a sequencer that walks the job table through its
// RAM read ports one job per cycle: an admission pass before the run, another
// after the run, a queue scan for shortest-job-first, and a compaction pass for
// a finishing job, with the sequencing states between them. With an empty queue
// a search for the next arrival and a second admission pass come first. The block
// takes no item while a dispatch is at work; a result waits in an output register.
module job_slice_scheduler_unit
    import jss_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [LEN_W-1:0]   s_arrival_time,
    input  logic [LEN_W-1:0]   s_run_length,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [CLK_W-1:0]   m_slice_start,
    output logic [ID_W-1:0]    m_job_id,
    output logic [LEN_W-1:0]   m_ran_for,
    output logic               m_job_finished,
    output logic [CLK_W-1:0]   m_resp_delay,
    output logic [CLK_W-1:0]   m_turn_delay,
    output logic [CLK_W-1:0]   m_queue_delay,
    output logic               m_all_done,
    output logic [SUM_W-1:0]   m_sum_response,
    output logic [SUM_W-1:0]   m_sum_turnaround,
    output logic [SUM_W-1:0]   m_sum_wait
);

    state_t                state_reg;
    scan_kind_t            kind_reg;
    logic [1:0]            policy_reg;
    logic [LEN_W-1:0]      tslice_reg;
    logic [CNT_W-1:0]      loaded_reg, finished_reg, count_reg, sc_reg;
    logic [MAX_JOBS-1:0]   adm_reg, started_reg, ran_reg;
    logic [CLK_W-1:0]      clock_reg;
    logic                  mset_reg;
    logic [ID_W-1:0]       mpos_reg, pos_reg, id_reg;
    logic                  pv_reg, v1_reg, v2_reg, rv_reg, found_reg;
    logic [ID_W-1:0]       pidx_reg, p1_reg, p2_reg, id2_reg, rp_reg;
    logic [LEN_W-1:0]      best_reg, arr_reg, rem_reg, run_reg;
    logic [CLK_W-1:0]      fs_reg, wt_reg, lastd_reg;
    logic [SUM_W-1:0]      sresp_reg, sturn_reg, swait_reg;
    logic [CLK_W-1:0]      res_start_reg, res_resp_reg, res_turn_reg, res_wait_reg;
    logic [ID_W-1:0]       res_id_reg;
    logic [LEN_W-1:0]      res_ran_reg;
    logic                  res_done_reg, res_alldone_reg;

    logic [LEN_W-1:0]      arr_rd, rem_rd;
    logic [CLK_W-1:0]      fs_rd, last_rd, wt_rd;
    logic [ID_W-1:0]       ro_rd;
    logic [ID_W-1:0]       arr_raddr, ro_raddr, rem_raddr, job_waddr, ro_waddr;
    logic                  load_acc, disp_acc, rem_we, job_we, ro_we, admit_hit, issue;
    logic [LEN_W-1:0]      rem_wdata;
    logic [ID_W-1:0]       ro_wdata;
    logic [CLK_W-1:0]      run_end;

    assign s_ready  = (state_reg == S_IDLE);
    assign load_acc = s_valid && s_ready && !s_mode && (loaded_reg < CNT_W'(MAX_JOBS));
    assign disp_acc = s_valid && s_ready && s_mode;
    assign issue    = (sc_reg < ((state_reg == S_SCAN) ? loaded_reg : count_reg));
    assign run_end  = clock_reg + {{PAD_W{1'b0}}, run_reg};
    assign admit_hit = !adm_reg[pidx_reg] && ({{PAD_W{1'b0}}, arr_rd} <= clock_reg);

    // Read and write addresses of the job and queue memories.
    always_comb begin
        arr_raddr = (state_reg == S_SCAN) ? sc_reg[ID_W-1:0] : id_reg;
        ro_raddr  = (state_reg == S_SJF || state_reg == S_REMOVE) ? sc_reg[ID_W-1:0]
                                                                   : pos_reg;
        rem_raddr = (state_reg == S_SJF) ? ro_rd : id_reg;
        job_waddr = load_acc ? loaded_reg[ID_W-1:0] : id_reg;
        job_we    = (state_reg == S_CALC);
        rem_we    = load_acc || job_we;
        rem_wdata = load_acc ? s_run_length : rem_reg - run_reg;
        ro_we     = ((state_reg == S_SCAN) && pv_reg && (kind_reg != K_MIN) && admit_hit)
                    || ((state_reg == S_REMOVE) && rv_reg);
        ro_waddr  = (state_reg == S_SCAN) ? count_reg[ID_W-1:0] : rp_reg - ID_W'(1);
        ro_wdata  = (state_reg == S_SCAN) ? pidx_reg : ro_rd;
    end

    jss_ram #(.DEPTH(MAX_JOBS), .WIDTH(LEN_W)) u_arr (
        .aclk(aclk), .we(load_acc), .waddr(loaded_reg[ID_W-1:0]), .wdata(s_arrival_time),
        .raddr(arr_raddr), .rdata(arr_rd));
    jss_ram #(.DEPTH(MAX_JOBS), .WIDTH(LEN_W)) u_rem (
        .aclk(aclk), .we(rem_we), .waddr(job_waddr), .wdata(rem_wdata),
        .raddr(rem_raddr), .rdata(rem_rd));
    jss_ram #(.DEPTH(MAX_JOBS), .WIDTH(CLK_W)) u_fs (
        .aclk(aclk), .we(job_we), .waddr(id_reg), .wdata(fs_reg),
        .raddr(id_reg), .rdata(fs_rd));
    jss_ram #(.DEPTH(MAX_JOBS), .WIDTH(CLK_W)) u_last (
        .aclk(aclk), .we(job_we), .waddr(id_reg), .wdata(run_end),
        .raddr(id_reg), .rdata(last_rd));
    jss_ram #(.DEPTH(MAX_JOBS), .WIDTH(CLK_W)) u_wt (
        .aclk(aclk), .we(job_we), .waddr(id_reg), .wdata(wt_reg + lastd_reg),
        .raddr(id_reg), .rdata(wt_rd));
    jss_ram #(.DEPTH(MAX_JOBS), .WIDTH(ID_W)) u_ro (
        .aclk(aclk), .we(ro_we), .waddr(ro_waddr), .wdata(ro_wdata),
        .raddr(ro_raddr), .rdata(ro_rd));

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= POL_FIFO;
            tslice_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_POLICY:    policy_reg <= cfg_wdata[1:0];
                CFG_TIMESLICE: tslice_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Dispatch sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            kind_reg     <= K_ADM_PRE;
            loaded_reg   <= '0;
            finished_reg <= '0;
            count_reg    <= '0;
            adm_reg      <= '0;
            started_reg  <= '0;
            ran_reg      <= '0;
            clock_reg    <= '0;
            mset_reg     <= 1'b0;
            mpos_reg     <= '0;
            sresp_reg    <= '0;
            sturn_reg    <= '0;
            swait_reg    <= '0;
            pv_reg       <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            rv_reg       <= 1'b0;
            m_valid      <= 1'b0;
        end else begin
            if (m_valid && m_ready && state_reg != S_EMIT) begin
                m_valid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (load_acc) begin
                        adm_reg[loaded_reg[ID_W-1:0]]     <= 1'b0;
                        started_reg[loaded_reg[ID_W-1:0]] <= 1'b0;
                        ran_reg[loaded_reg[ID_W-1:0]]     <= 1'b0;
                        loaded_reg <= loaded_reg + CNT_W'(1);
                    end
                    if (disp_acc) begin
                        res_start_reg   <= '0;
                        res_id_reg      <= '0;
                        res_ran_reg     <= '0;
                        res_done_reg    <= 1'b0;
                        res_resp_reg    <= '0;
                        res_turn_reg    <= '0;
                        res_wait_reg    <= '0;
                        res_alldone_reg <= 1'b0;
                        kind_reg  <= K_ADM_PRE;
                        sc_reg    <= '0;
                        pv_reg    <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                // Pass over the job table: admission or next-arrival search.
                S_SCAN: begin
                    if (pv_reg) begin
                        if (kind_reg == K_MIN) begin
                            if (!adm_reg[pidx_reg] && (!found_reg || arr_rd < best_reg)) begin
                                best_reg  <= arr_rd;
                                found_reg <= 1'b1;
                            end
                        end else if (admit_hit) begin
                            adm_reg[pidx_reg] <= 1'b1;
                            count_reg <= count_reg + CNT_W'(1);
                        end
                    end
                    pv_reg   <= issue;
                    pidx_reg <= sc_reg[ID_W-1:0];
                    if (issue) begin
                        sc_reg <= sc_reg + CNT_W'(1);
                    end
                    if (!issue && !pv_reg) begin
                        sc_reg <= '0;
                        unique case (kind_reg)
                            K_ADM_PRE, K_ADM_JUMP: begin
                                if (count_reg == '0 && kind_reg == K_ADM_PRE) begin
                                    kind_reg  <= K_MIN;
                                    found_reg <= 1'b0;
                                end else if (count_reg == '0) begin
                                    res_alldone_reg <= 1'b1;
                                    state_reg <= S_EMIT;
                                end else if (policy_reg == POL_SJF) begin
                                    v1_reg    <= 1'b0;
                                    v2_reg    <= 1'b0;
                                    state_reg <= S_SJF;
                                end else begin
                                    pos_reg <= (policy_reg == POL_RR && mset_reg) ? mpos_reg
                                                                                   : '0;
                                    state_reg <= S_RDID;
                                end
                            end
                            K_MIN: begin
                                if (!found_reg) begin
                                    res_alldone_reg <= 1'b1;
                                    state_reg <= S_EMIT;
                                end else begin
                                    if ({{PAD_W{1'b0}}, best_reg} > clock_reg) begin
                                        clock_reg <= {{PAD_W{1'b0}}, best_reg};
                                    end
                                    kind_reg <= K_ADM_JUMP;
                                end
                            end
                            K_ADM_POST: state_reg <= S_MARK;
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                // Shortest remaining length over the queue, earliest entry on ties.
                S_SJF: begin
                    v1_reg  <= issue;
                    p1_reg  <= sc_reg[ID_W-1:0];
                    v2_reg  <= v1_reg;
                    p2_reg  <= p1_reg;
                    id2_reg <= ro_rd;
                    if (issue) begin
                        sc_reg <= sc_reg + CNT_W'(1);
                    end
                    if (v2_reg && (p2_reg == '0 || rem_rd < best_reg)) begin
                        best_reg <= rem_rd;
                        pos_reg  <= p2_reg;
                        id_reg   <= id2_reg;
                    end
                    if (!issue && !v1_reg && !v2_reg) begin
                        state_reg <= S_JOBRD;
                    end
                end
                S_RDID: state_reg <= S_GETID;
                S_GETID: begin
                    id_reg    <= ro_rd;
                    state_reg <= S_JOBRD;
                end
                S_JOBRD: state_reg <= S_JOBDAT;
                // Job entry read back: first start, waiting so far, slice length.
                S_JOBDAT: begin
                    arr_reg <= arr_rd;
                    rem_reg <= rem_rd;
                    fs_reg  <= started_reg[id_reg] ? fs_rd : clock_reg;
                    wt_reg  <= started_reg[id_reg] ? wt_rd
                                                   : clock_reg - {{PAD_W{1'b0}}, arr_rd};
                    lastd_reg <= ran_reg[id_reg] ? clock_reg - last_rd : '0;
                    run_reg <= (tslice_reg != '0 && tslice_reg < rem_rd) ? tslice_reg : rem_rd;
                    res_start_reg <= clock_reg;
                    res_id_reg    <= id_reg;
                    state_reg <= S_CALC;
                end
                // Run the slice and write the job entry back.
                S_CALC: begin
                    started_reg[id_reg] <= 1'b1;
                    ran_reg[id_reg]     <= 1'b1;
                    wt_reg      <= wt_reg + lastd_reg;
                    rem_reg     <= rem_reg - run_reg;
                    clock_reg   <= run_end;
                    res_ran_reg <= run_reg;
                    kind_reg    <= K_ADM_POST;
                    sc_reg      <= '0;
                    pv_reg      <= 1'b0;
                    state_reg   <= S_SCAN;
                end
                // Move the round-robin marker by queue position.
                S_MARK: begin
                    if (mset_reg) begin
                        mpos_reg <= ({1'b0, mpos_reg} + CNT_W'(1) < count_reg)
                                    ? mpos_reg + ID_W'(1) : '0;
                    end else if (count_reg > CNT_W'(1)) begin
                        mpos_reg <= ID_W'(1);
                        mset_reg <= 1'b1;
                    end
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    res_done_reg <= (rem_reg == '0);
                    res_resp_reg <= fs_reg - {{PAD_W{1'b0}}, arr_reg};
                    res_turn_reg <= clock_reg - {{PAD_W{1'b0}}, arr_reg};
                    res_wait_reg <= wt_reg;
                    state_reg <= S_SUM;
                end
                // Metrics of a finished job; start taking it out of the queue.
                S_SUM: begin
                    if (res_done_reg) begin
                        sresp_reg <= sresp_reg + {{(SUM_W-CLK_W){1'b0}}, res_resp_reg};
                        sturn_reg <= sturn_reg + {{(SUM_W-CLK_W){1'b0}}, res_turn_reg};
                        swait_reg <= swait_reg + {{(SUM_W-CLK_W){1'b0}}, res_wait_reg};
                        finished_reg <= finished_reg + CNT_W'(1);
                        if (mset_reg && mpos_reg == pos_reg) begin
                            mset_reg <= 1'b0;
                        end else if (mset_reg && mpos_reg > pos_reg) begin
                            mpos_reg <= mpos_reg - ID_W'(1);
                        end
                        sc_reg    <= {1'b0, pos_reg} + CNT_W'(1);
                        rv_reg    <= 1'b0;
                        state_reg <= S_REMOVE;
                    end else begin
                        res_resp_reg <= '0;
                        res_turn_reg <= '0;
                        res_wait_reg <= '0;
                        state_reg <= S_EMIT;
                    end
                end
                // Compact the queue over the removed entry.
                S_REMOVE: begin
                    rv_reg <= issue;
                    rp_reg <= sc_reg[ID_W-1:0];
                    if (issue) begin
                        sc_reg <= sc_reg + CNT_W'(1);
                    end
                    if (!issue && !rv_reg) begin
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= S_EMIT;
                    end
                end
                // Hand the result to the output register once it is free.
                S_EMIT: begin
                    if (!m_valid || m_ready) begin
                        m_valid           <= 1'b1;
                        m_slice_start     <= res_start_reg;
                        m_job_id          <= res_id_reg;
                        m_ran_for         <= res_ran_reg;
                        m_job_finished    <= res_done_reg;
                        m_resp_delay      <= res_resp_reg;
                        m_turn_delay      <= res_turn_reg;
                        m_queue_delay     <= res_wait_reg;
                        m_all_done        <= res_alldone_reg;
                        m_sum_response    <= sresp_reg;
                        m_sum_turnaround  <= sturn_reg;
                        m_sum_wait        <= swait_reg;
                        state_reg         <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Checks on the queue bookkeeping.
    a_count_le_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= loaded_reg)
        else $error("ready queue holds more jobs than were loaded");
    a_marker_in_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        (mset_reg && state_reg == S_IDLE) |-> ({1'b0, mpos_reg} < count_reg))
        else $error("rotation marker points past the ready queue");
    a_finished_le_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> ((finished_reg + count_reg) <= loaded_reg))
        else $error("finished and ready jobs exceed loaded jobs");
    a_alldone_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_all_done) |-> (!m_job_finished && m_ran_for == '0))
        else $error("all-done item carries a slice");

endmodule

>>> tb/sv/tb_job_slice_scheduler_unit.sv
// ----------------------------------------------------------------------------
// tb_job_slice_scheduler_unit: self-checking testbench of the slice scheduler
// Loads jobs and dispatches slices under every policy and several timeslices,
// predicts each slice result with an in-bench scheduler and compares fields.
// ----------------------------------------------------------------------------
module tb_job_slice_scheduler_unit;
    import jss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_LOAD     = 1'b0;
    localparam logic MODE_DISPATCH = 1'b1;
    localparam int   SETTLE_CYCLES = 500;
    localparam int   STALL_LIMIT   = 5000;

    typedef struct {
        logic             mode;
        logic [LEN_W-1:0] arrival;
        logic [LEN_W-1:0] length;
    } job_item_t;

    typedef struct {
        logic [CLK_W-1:0] slice_start;
        logic [ID_W-1:0]  job_id;
        logic [LEN_W-1:0] ran_for;
        logic             finished;
        logic [CLK_W-1:0] response;
        logic [CLK_W-1:0] turnaround;
        logic [CLK_W-1:0] waited;
        logic             all_done;
        logic [SUM_W-1:0] sum_resp;
        logic [SUM_W-1:0] sum_turn;
        logic [SUM_W-1:0] sum_wait;
    } slice_t;

    logic             aclk;
    logic             aresetn;
    logic             cfg_wr_en;
    logic             cfg_index;
    logic [15:0]      cfg_wdata;
    logic             s_valid;
    logic             s_ready;
    logic             s_mode;
    logic [LEN_W-1:0] s_arrival_time;
    logic [LEN_W-1:0] s_run_length;
    logic             m_valid;
    logic             m_ready;
    logic [CLK_W-1:0] m_slice_start;
    logic [ID_W-1:0]  m_job_id;
    logic [LEN_W-1:0] m_ran_for;
    logic             m_job_finished;
    logic [CLK_W-1:0] m_resp_delay;
    logic [CLK_W-1:0] m_turn_delay;
    logic [CLK_W-1:0] m_queue_delay;
    logic             m_all_done;
    logic [SUM_W-1:0] m_sum_response;
    logic [SUM_W-1:0] m_sum_turnaround;
    logic [SUM_W-1:0] m_sum_wait;

    job_item_t pending_items[$];
    slice_t    expected_slices[$];
    int        error_count = 0;
    bit        quiet = 0;
    int        send_gap = 0;
    int        recv_gap = 0;
    int        stall_cycles = 0;

    // Scheduler state mirrored by the predictor.
    logic [1:0]       sched_policy;
    logic [LEN_W-1:0] slice_len;
    longint           job_arrival[MAX_JOBS];
    longint           job_left[MAX_JOBS];
    longint           job_first[MAX_JOBS];
    bit               job_started[MAX_JOBS];
    longint           job_last[MAX_JOBS];
    bit               job_ran[MAX_JOBS];
    longint           job_waited[MAX_JOBS];
    bit               job_admitted[MAX_JOBS];
    int               ready_q[$];
    int               rr_marker;
    bit               rr_valid;
    longint           now;
    int               loaded;
    longint           sums[3];

    job_slice_scheduler_unit dut (.*);

    // Clock.
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Move every arrived job into the ready queue in load order.
    function automatic void admit_jobs();
        for (int i = 0; i < loaded; i++) begin
            if (!job_admitted[i] && job_arrival[i] <= now) begin
                job_admitted[i] = 1'b1;
                ready_q.push_back(i);
            end
        end
    endfunction

    function automatic int pick_slot();
        int best;
        best = 0;
        if (sched_policy == POL_SJF) begin
            for (int p = 1; p < ready_q.size(); p++)
                if (job_left[ready_q[p]] < job_left[ready_q[best]]) best = p;
        end else if (sched_policy == POL_RR && rr_valid) begin
            for (int p = 0; p < ready_q.size(); p++)
                if (ready_q[p] == rr_marker) return p;
        end
        return best;
    endfunction

    function automatic void rotate_marker();
        if (ready_q.size() == 0) return;
        if (rr_valid) begin
            for (int p = 0; p < ready_q.size(); p++) begin
                if (ready_q[p] == rr_marker) begin
                    rr_marker = (p + 1 < ready_q.size()) ? ready_q[p + 1] : ready_q[0];
                    return;
                end
            end
        end
        if (ready_q.size() > 1) begin
            rr_marker = ready_q[1];
            rr_valid  = 1'b1;
        end
    endfunction

    // Expected result of one dispatch item.
    function automatic slice_t run_slice();
        slice_t r;
        int     id;
        bit     found;
        longint soonest, start, run;
        r = '{default: '0};
        found = 1'b0;
        soonest = 0;
        r.sum_resp = SUM_W'(sums[0]);
        r.sum_turn = SUM_W'(sums[1]);
        r.sum_wait = SUM_W'(sums[2]);
        admit_jobs();
        if (ready_q.size() == 0) begin
            for (int i = 0; i < loaded; i++)
                if (!job_admitted[i] && (!found || job_arrival[i] < soonest)) begin
                    soonest = job_arrival[i];
                    found = 1'b1;
                end
            if (!found) begin
                r.all_done = 1'b1;
                return r;
            end
            if (soonest > now) now = soonest;
            admit_jobs();
        end
        id = ready_q[pick_slot()];
        start = now;
        if (!job_started[id]) begin
            job_started[id] = 1'b1;
            job_first[id] = start;
            job_waited[id] = start - job_arrival[id];
        end
        if (job_ran[id]) job_waited[id] += start - job_last[id];
        run = job_left[id];
        if (slice_len != 0 && slice_len < run) run = slice_len;
        job_left[id] -= run;
        now = start + run;
        job_last[id] = now;
        job_ran[id] = 1'b1;
        admit_jobs();
        rotate_marker();
        r.slice_start = CLK_W'(start);
        r.job_id = ID_W'(id);
        r.ran_for = LEN_W'(run);
        if (job_left[id] == 0) begin
            r.finished = 1'b1;
            r.response = CLK_W'(job_first[id] - job_arrival[id]);
            r.turnaround = CLK_W'(now - job_arrival[id]);
            r.waited = CLK_W'(job_waited[id]);
            sums[0] += longint'(r.response);
            sums[1] += longint'(r.turnaround);
            sums[2] += longint'(r.waited);
            for (int p = ready_q.size() - 1; p >= 0; p--)
                if (ready_q[p] == id) ready_q.delete(p);
            if (rr_valid && rr_marker == id) rr_valid = 1'b0;
        end
        r.sum_resp = SUM_W'(sums[0]);
        r.sum_turn = SUM_W'(sums[1]);
        r.sum_wait = SUM_W'(sums[2]);
        return r;
    endfunction

    function automatic void take_item(job_item_t it);
        if (it.mode == MODE_DISPATCH) begin
            expected_slices.push_back(run_slice());
        end else if (loaded < MAX_JOBS) begin
            job_arrival[loaded] = longint'(it.arrival);
            job_left[loaded] = longint'(it.length);
            loaded++;
        end
    endfunction

    // Driver: presents queued items, with random gaps between them.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                take_item('{s_mode, s_arrival_time, s_run_length});
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 9) == 0) begin
                    send_gap <= $urandom_range(1, 15);
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    job_item_t it;
                    it = pending_items.pop_front();
                    s_valid <= 1'b1;
                    s_mode <= it.mode;
                    s_arrival_time <= it.arrival;
                    s_run_length <= it.length;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
        end
    endfunction

    // Monitor: compares each accepted result with the oldest expected one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_slices.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, job %0d", $realtime, m_job_id);
                end else begin
                    slice_t e;
                    e = expected_slices.pop_front();
                    check_field("slice_start", longint'(e.slice_start),
                                longint'(m_slice_start));
                    check_field("job_id", longint'(e.job_id), longint'(m_job_id));
                    check_field("ran_for", longint'(e.ran_for), longint'(m_ran_for));
                    check_field("job_finished", longint'(e.finished),
                                longint'(m_job_finished));
                    check_field("resp_delay", longint'(e.response), longint'(m_resp_delay));
                    check_field("turn_delay", longint'(e.turnaround),
                                longint'(m_turn_delay));
                    check_field("queue_delay", longint'(e.waited), longint'(m_queue_delay));
                    check_field("all_done", longint'(e.all_done), longint'(m_all_done));
                    check_field("sum_response", longint'(e.sum_resp),
                                longint'(m_sum_response));
                    check_field("sum_turnaround", longint'(e.sum_turn),
                                longint'(m_sum_turnaround));
                    check_field("sum_wait", longint'(e.sum_wait), longint'(m_sum_wait));
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                recv_gap <= $urandom_range(1, 15);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en || !aresetn)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_job_slice_scheduler_unit: done, errors");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_valid || expected_slices.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == CFG_POLICY) sched_policy = val[1:0];
        else slice_len = val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic void queue_item(logic mode, int arr, int len);
        pending_items.push_back('{mode, arr[LEN_W-1:0], len[LEN_W-1:0]});
    endfunction

    function automatic int rand_length();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7) return $urandom_range(1, 30);
        if (sel < 9) return $urandom_range(1, 2000);
        return $urandom_range(1, 65535);
    endfunction

    // Stimulus.
    initial begin
        int last_arrival;
        logic [15:0] slices [10];
        slices = '{16'd0, 16'd1, 16'd65535, 16'd4, 16'd0, 16'd2, 16'd7, 16'd1,
                   16'd65535, 16'd3};
        last_arrival = 0;
        sched_policy = POL_FIFO;
        slice_len = '0;
        rr_valid = 1'b0;
        rr_marker = 0;
        now = 0;
        loaded = 0;
        sums = '{0, 0, 0};
        for (int i = 0; i < MAX_JOBS; i++) begin
            job_admitted[i] = 1'b0;
            job_started[i] = 1'b0;
            job_ran[i] = 1'b0;
        end
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_POLICY;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_mode = MODE_LOAD;
        s_arrival_time = '0;
        s_run_length = '0;
        m_ready = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty dispatch, short and longest jobs, a jump to a late arrival.
        write_reg(CFG_POLICY, {14'd0, POL_FIFO});
        write_reg(CFG_TIMESLICE, 16'd0);
        queue_item(MODE_DISPATCH, 0, 0);
        queue_item(MODE_LOAD, 0, 1);
        queue_item(MODE_LOAD, 0, 65535);
        queue_item(MODE_LOAD, 10, 3);
        repeat (4) queue_item(MODE_DISPATCH, 0, 0);
        queue_item(MODE_LOAD, 40000, 2);
        repeat (2) queue_item(MODE_DISPATCH, 0, 0);
        last_arrival = 40000;
        wait_idle();
        // A directed round under shortest-job-first on a fresh burst of jobs.
        write_reg(CFG_POLICY, {14'd0, POL_SJF});
        write_reg(CFG_TIMESLICE, 16'd2);
        queue_item(MODE_LOAD, 40000, 9);
        queue_item(MODE_LOAD, 40000, 3);
        queue_item(MODE_LOAD, 40001, 3);
        repeat (5) queue_item(MODE_DISPATCH, 0, 0);
        wait_idle();

        // Random phases, each under its own policy and timeslice.
        for (int ph = 0; ph < 10; ph++) begin
            int budget;
            write_reg(CFG_POLICY, 16'(ph % 4));
            write_reg(CFG_TIMESLICE, slices[ph]);
            if (ph == 9) quiet = 1'b1;
            budget = 0;
            for (int k = 0; k < 6; k++) begin
                last_arrival += $urandom_range(0, 40);
                if (last_arrival > 65535 || ph == 9) last_arrival = 65535;
                queue_item(MODE_LOAD, last_arrival, rand_length());
            end
            while (budget < 115) begin
                if ($urandom_range(0, 9) == 0) begin
                    if ($urandom_range(0, 7) == 0) last_arrival += $urandom_range(0, 9000);
                    else last_arrival += $urandom_range(0, 30);
                    if (last_arrival > 65535) last_arrival = 65535;
                    queue_item(MODE_LOAD, last_arrival, rand_length());
                end else begin
                    queue_item(MODE_DISPATCH, $urandom_range(0, 65535), $urandom_range(0, 65535));
                end
                budget++;
            end
            wait_idle();
        end

        if (error_count == 0) begin
            $display("tb_job_slice_scheduler_unit: done, clean");
        end else begin
            $display("tb_job_slice_scheduler_unit: done, errors");
        end
        $finish;
    end

endmodule
